// ----- rtl/glrd_pkg.sv -----
`timescale 1ns / 1ps
// shared types and codes for the gouraud line rasterizer
// no dependencies
package glrd_pkg;

   typedef enum logic [1:0] {
      CMD_SINGLE = 2'd0,
      CMD_FIRST  = 2'd1,
      CMD_CONT   = 2'd2,
      CMD_TICK   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      JOB_TICK   = 2'd0,
      JOB_SETUP  = 2'd1,
      JOB_REJECT = 2'd2
   } job_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_FIN  = 3'b100
   } back_state_type;

   localparam logic [2:0] REG_OFFSET_X    = 3'd0;
   localparam logic [2:0] REG_OFFSET_Y    = 3'd1;
   localparam logic [2:0] REG_CLIP_LEFT   = 3'd2;
   localparam logic [2:0] REG_CLIP_RIGHT  = 3'd3;
   localparam logic [2:0] REG_CLIP_TOP    = 3'd4;
   localparam logic [2:0] REG_CLIP_BOTTOM = 3'd5;

   typedef struct packed {
      logic signed [11:0] x;
      logic signed [11:0] y;
      logic [7:0]         r;
      logic [7:0]         g;
      logic [7:0]         b;
   } vertex_type;

   typedef struct packed {
      job_kind_type      kind;
      vertex_type        p0;
      logic [10:0]       k;
      logic [9:0]        dx_mag;
      logic [10:0]       dy;
      logic [8:0]        dr;
      logic [8:0]        dg;
      logic [8:0]        db;
   } job_type;

   typedef struct packed {
      logic [9:0] left;
      logic [9:0] right;
      logic [9:0] top;
      logic [9:0] bottom;
   } clip_type;

   typedef struct packed {
      logic        pixel_valid;
      logic [10:0] pixel_x;
      logic [10:0] pixel_y;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        last_pixel;
      logic        line_rejected;
   } rsp_type;

endpackage

// ----- rtl/glrd_if.sv -----
`timescale 1ns / 1ps
// command and pixel channel interfaces
// no dependencies
interface glrd_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        cmd;
   logic              gouraud;
   logic signed [10:0] start_x;
   logic signed [10:0] start_y;
   logic [7:0]        start_red;
   logic [7:0]        start_green;
   logic [7:0]        start_blue;
   logic signed [10:0] end_x;
   logic signed [10:0] end_y;
   logic [7:0]        end_red;
   logic [7:0]        end_green;
   logic [7:0]        end_blue;

   modport source (output valid, cmd, gouraud, start_x, start_y, start_red, start_green,
                   start_blue, end_x, end_y, end_red, end_green, end_blue, input ready);
   modport sink (input valid, cmd, gouraud, start_x, start_y, start_red, start_green,
                 start_blue, end_x, end_y, end_red, end_green, end_blue, output ready);
endinterface

interface glrd_rsp_if;
   logic        valid;
   logic        ready;
   logic        pixel_valid;
   logic [10:0] pixel_x;
   logic [10:0] pixel_y;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic        last_pixel;
   logic        line_rejected;

   modport source (output valid, pixel_valid, pixel_x, pixel_y, red, green, blue,
                   last_pixel, line_rejected, input ready);
   modport sink (input valid, pixel_valid, pixel_x, pixel_y, red, green, blue,
                 last_pixel, line_rejected, output ready);
endinterface

// ----- rtl/glrd_front.sv -----
`timescale 1ns / 1ps
// command decode: vertex assembly, length check, endpoint order and deltas
// depends on glrd_pkg and glrd_if
module glrd_front import glrd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   glrd_req_if.sink            req_bus,
   input  logic signed [10:0]  offset_x,
   input  logic signed [10:0]  offset_y,
   input  logic                q_full,
   output logic                q_push,
   output job_type             q_job
);

   vertex_type         prev_ff, prev_in;
   vertex_type         p0, p1, va, vb;
   logic signed [12:0] dx, dy, dys;
   logic [12:0]        adx, ady;
   logic               reject, swap;
   cmd_type            cmd;

   assign req_bus.ready = !q_full;
   assign q_push        = req_bus.valid && !q_full;
   assign cmd           = cmd_type'(req_bus.cmd);

   always_comb begin
      if (cmd == CMD_CONT) begin
         p0 = prev_ff;
      end else begin
         p0.x = 12'($signed(req_bus.start_x)) + 12'($signed(offset_x));
         p0.y = 12'($signed(req_bus.start_y)) + 12'($signed(offset_y));
         p0.r = req_bus.start_red;
         p0.g = req_bus.start_green;
         p0.b = req_bus.start_blue;
      end
      p1.x = 12'($signed(req_bus.end_x)) + 12'($signed(offset_x));
      p1.y = 12'($signed(req_bus.end_y)) + 12'($signed(offset_y));
      p1.r = req_bus.gouraud ? req_bus.end_red   : p0.r;
      p1.g = req_bus.gouraud ? req_bus.end_green : p0.g;
      p1.b = req_bus.gouraud ? req_bus.end_blue  : p0.b;

      dx  = 13'(p1.x) - 13'(p0.x);
      dy  = 13'(p1.y) - 13'(p0.y);
      adx = dx[12] ? 13'(-dx) : 13'(dx);
      ady = dy[12] ? 13'(-dy) : 13'(dy);
      reject = (adx >= 13'd1024) || (ady >= 13'd512);
      swap   = p0.x > p1.x;
      va     = swap ? p1 : p0;
      vb     = swap ? p0 : p1;
      dys    = 13'(vb.y) - 13'(va.y);

      q_job.p0     = va;
      q_job.k      = (adx > ady) ? adx[10:0] : ady[10:0];
      q_job.dx_mag = adx[9:0];
      q_job.dy     = dys[10:0];
      q_job.dr     = {1'b0, vb.r} - {1'b0, va.r};
      q_job.dg     = {1'b0, vb.g} - {1'b0, va.g};
      q_job.db     = {1'b0, vb.b} - {1'b0, va.b};
      if (cmd == CMD_TICK) begin
         q_job.kind = JOB_TICK;
      end else if (reject) begin
         q_job.kind = JOB_REJECT;
      end else begin
         q_job.kind = JOB_SETUP;
      end

      prev_in = prev_ff;
      if (q_push && (cmd == CMD_FIRST || cmd == CMD_CONT)) begin
         prev_in = p1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else begin
         prev_ff <= prev_in;
      end
   end

endmodule

// ----- rtl/glrd_queue.sv -----
`timescale 1ns / 1ps
// two-entry queue between decode and the line engine
// depends on glrd_pkg
module glrd_queue import glrd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output job_type head_job
);

   job_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = count_ff == 2'd2;
   assign empty    = count_ff == 2'd0;
   assign head_job = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/glrd_back.sv -----
`timescale 1ns / 1ps
// line engine: step dividers, position and colour accumulators, pixel output register
// depends on glrd_pkg
module glrd_back import glrd_pkg::*; #(
   parameter int POS_FRAC_BITS    = 32,
   parameter int COLOUR_FRAC_BITS = 12
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   input  job_type q_job,
   output logic    q_pop,
   input  clip_type clip,
   output rsp_type rsp_data,
   output logic    rsp_valid,
   input  logic    rsp_ready
);

   localparam int PF     = POS_FRAC_BITS;
   localparam int CF     = COLOUR_FRAC_BITS;
   localparam int POS_W  = 12 + PF;
   localparam int CACC_W = 8 + CF;
   localparam int CSTP_W = 9 + CF;
   localparam int DW     = 10 + PF;
   localparam int CNT_W  = $clog2(DW + 1);

   back_state_type    state_ff, state_in;
   job_type           job_ff, job_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DW-1:0]     num_ff [5];
   logic [DW-1:0]     num_in [5];
   logic [9:0]        rem_ff [5];
   logic [9:0]        rem_in [5];
   logic [POS_W-1:0]  posx_ff, posx_in, posy_ff, posy_in;
   logic [POS_W-1:0]  stepx_ff, stepx_in, stepy_ff, stepy_in;
   logic [CACC_W-1:0] cacc_ff [3];
   logic [CACC_W-1:0] cacc_in [3];
   logic [CSTP_W-1:0] cstep_ff [3];
   logic [CSTP_W-1:0] cstep_in [3];
   logic [10:0]       left_ff, left_in;
   logic              active_ff, active_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              slot_free;
   logic [10:0]       part [5];
   logic              ge [5];
   logic [10:0]       dy_abs;
   logic [8:0]        dc [3];
   logic [8:0]        dc_abs [3];
   logic [POS_W-1:0]  qx, qy, start_x, start_y;
   logic [CSTP_W-1:0] qc;
   logic [10:0]       px, py;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      dc[0] = q_job.dr;
      dc[1] = q_job.dg;
      dc[2] = q_job.db;
      dy_abs = q_job.dy[10] ? 11'(-q_job.dy) : q_job.dy;
      for (int i = 0; i < 3; i++) begin
         dc_abs[i] = dc[i][8] ? 9'(-dc[i]) : dc[i];
      end
      for (int i = 0; i < 5; i++) begin
         part[i] = {rem_ff[i], num_ff[i][DW-1]};
         ge[i]   = part[i] >= job_ff.k;
      end
      px = posx_ff[PF+10:PF];
      py = posy_ff[PF+10:PF];
      qx = POS_W'(num_ff[0]) + POS_W'(rem_ff[0] != 10'd0);
      qy = POS_W'(num_ff[1]) + POS_W'(rem_ff[1] != 10'd0);
      start_x = {job_ff.p0.x, {PF{1'b0}}} | (POS_W'(1) << (PF - 1));
      start_y = {job_ff.p0.y, {PF{1'b0}}} | (POS_W'(1) << (PF - 1));
      qc = '0;

      state_in     = state_ff;
      job_in       = job_ff;
      cnt_in       = cnt_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      posx_in      = posx_ff;
      posy_in      = posy_ff;
      stepx_in     = stepx_ff;
      stepy_in     = stepy_ff;
      cacc_in      = cacc_ff;
      cstep_in     = cstep_ff;
      left_in      = left_ff;
      active_in    = active_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      q_pop        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               priority case (q_job.kind)
                  JOB_SETUP: begin
                     q_pop     = 1'b1;
                     active_in = 1'b0;
                     job_in    = q_job;
                     cnt_in    = CNT_W'(DW);
                     num_in[0] = {q_job.dx_mag, {PF{1'b0}}};
                     num_in[1] = {dy_abs[9:0], {PF{1'b0}}};
                     for (int i = 0; i < 3; i++) begin
                        num_in[2+i] = {{(DW-8-CF){1'b0}}, dc_abs[i][7:0], {CF{1'b0}}};
                     end
                     for (int i = 0; i < 5; i++) begin
                        rem_in[i] = '0;
                     end
                     state_in = ST_DIV;
                  end
                  JOB_REJECT: begin
                     if (slot_free) begin
                        q_pop        = 1'b1;
                        active_in    = 1'b0;
                        rsp_in       = '0;
                        rsp_in.last_pixel    = 1'b1;
                        rsp_in.line_rejected = 1'b1;
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: begin
                     if (slot_free) begin
                        q_pop        = 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_in       = '0;
                        if (!active_ff) begin
                           rsp_in.last_pixel = 1'b1;
                        end else begin
                           rsp_in.pixel_x     = px;
                           rsp_in.pixel_y     = py;
                           rsp_in.red         = cacc_ff[0][CACC_W-1:CF];
                           rsp_in.green       = cacc_ff[1][CACC_W-1:CF];
                           rsp_in.blue        = cacc_ff[2][CACC_W-1:CF];
                           rsp_in.pixel_valid = (px >= {1'b0, clip.left}) &&
                                                (px <= {1'b0, clip.right}) &&
                                                (py >= {1'b0, clip.top}) &&
                                                (py <= {1'b0, clip.bottom});
                           rsp_in.last_pixel  = left_ff == 11'd0;
                           posx_in = posx_ff + stepx_ff;
                           posy_in = posy_ff + stepy_ff;
                           for (int i = 0; i < 3; i++) begin
                              cacc_in[i] = cacc_ff[i] + cstep_ff[i][CACC_W-1:0];
                           end
                           if (left_ff == 11'd0) begin
                              active_in = 1'b0;
                           end else begin
                              left_in = left_ff - 11'd1;
                           end
                        end
                     end
                  end
               endcase
            end
         end
         ST_DIV: begin
            for (int i = 0; i < 5; i++) begin
               rem_in[i] = ge[i] ? 10'(part[i] - job_ff.k) : part[i][9:0];
               num_in[i] = {num_ff[i][DW-2:0], ge[i]};
            end
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_FIN;
            end
         end
         default: begin
            if (slot_free) begin
               if (job_ff.k == 11'd0) begin
                  stepx_in = '0;
                  stepy_in = '0;
               end else begin
                  stepx_in = qx;
                  stepy_in = job_ff.dy[10] ? POS_W'(-qy) : qy;
               end
               posx_in = start_x - POS_W'(1024);
               posy_in = stepy_in[POS_W-1] ? start_y - POS_W'(1024) : start_y;
               dc[0] = job_ff.dr;
               dc[1] = job_ff.dg;
               dc[2] = job_ff.db;
               for (int i = 0; i < 3; i++) begin
                  qc = {1'b0, num_ff[2+i][CACC_W-1:0]};
                  if (job_ff.k == 11'd0) begin
                     cstep_in[i] = '0;
                  end else begin
                     cstep_in[i] = dc[i][8] ? CSTP_W'(-qc) : qc;
                  end
               end
               cacc_in[0] = {job_ff.p0.r, {CF{1'b0}}} | (CACC_W'(1) << (CF - 1));
               cacc_in[1] = {job_ff.p0.g, {CF{1'b0}}} | (CACC_W'(1) << (CF - 1));
               cacc_in[2] = {job_ff.p0.b, {CF{1'b0}}} | (CACC_W'(1) << (CF - 1));
               left_in      = job_ff.k;
               active_in    = 1'b1;
               rsp_in       = '0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         posx_ff      <= '0;
         posy_ff      <= '0;
         stepx_ff     <= '0;
         stepy_ff     <= '0;
         cacc_ff      <= '{default: '0};
         cstep_ff     <= '{default: '0};
         left_ff      <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         posx_ff      <= posx_in;
         posy_ff      <= posy_in;
         stepx_ff     <= stepx_in;
         stepy_ff     <= stepy_in;
         cacc_ff      <= cacc_in;
         cstep_ff     <= cstep_in;
         left_ff      <= left_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/gouraud_line_dda_rasterizer.sv -----
`timescale 1ns / 1ps
// Gouraud DDA line rasterizer top level. Each accepted command beat gives one result beat.
// Step ticks stream at one pixel per cycle while the result is taken. A line setup runs
// five restoring dividers side by side, one quotient bit per cycle. A two-entry queue lets
// decode take commands while the line engine works. No clearing pass after reset.
// Depends on glrd_pkg, glrd_if, glrd_front, glrd_queue, glrd_back.
module gouraud_line_dda_rasterizer import glrd_pkg::*; #(
   parameter int POS_FRAC_BITS    = 32,
   parameter int COLOUR_FRAC_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   glrd_req_if.sink    req_bus,
   glrd_rsp_if.source  rsp_bus,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic signed [10:0] offx_ff, offy_ff;
   clip_type           clip_ff;
   logic               q_push, q_full, q_pop, q_empty;
   job_type            push_job, head_job;
   rsp_type            rsp;
   logic [2:0]         reg_index;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[4:2];

   always_comb begin
      unique case (reg_index)
         REG_OFFSET_X:    csr_prdata = {21'd0, offx_ff};
         REG_OFFSET_Y:    csr_prdata = {21'd0, offy_ff};
         REG_CLIP_LEFT:   csr_prdata = {22'd0, clip_ff.left};
         REG_CLIP_RIGHT:  csr_prdata = {22'd0, clip_ff.right};
         REG_CLIP_TOP:    csr_prdata = {22'd0, clip_ff.top};
         REG_CLIP_BOTTOM: csr_prdata = {22'd0, clip_ff.bottom};
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offx_ff        <= '0;
         offy_ff        <= '0;
         clip_ff.left   <= 10'd0;
         clip_ff.right  <= 10'd1023;
         clip_ff.top    <= 10'd0;
         clip_ff.bottom <= 10'd511;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (reg_index)
            REG_OFFSET_X:    offx_ff        <= csr_pwdata[10:0];
            REG_OFFSET_Y:    offy_ff        <= csr_pwdata[10:0];
            REG_CLIP_LEFT:   clip_ff.left   <= csr_pwdata[9:0];
            REG_CLIP_RIGHT:  clip_ff.right  <= csr_pwdata[9:0];
            REG_CLIP_TOP:    clip_ff.top    <= csr_pwdata[9:0];
            REG_CLIP_BOTTOM: clip_ff.bottom <= csr_pwdata[9:0];
            default: begin
            end
         endcase
      end
   end

   glrd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .offset_x (offx_ff),
      .offset_y (offy_ff),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_job    (push_job)
   );

   glrd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head_job (head_job)
   );

   glrd_back #(
      .POS_FRAC_BITS    (POS_FRAC_BITS),
      .COLOUR_FRAC_BITS (COLOUR_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_job     (head_job),
      .q_pop     (q_pop),
      .clip      (clip_ff),
      .rsp_data  (rsp),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready)
   );

   assign rsp_bus.pixel_valid   = rsp.pixel_valid;
   assign rsp_bus.pixel_x       = rsp.pixel_x;
   assign rsp_bus.pixel_y       = rsp.pixel_y;
   assign rsp_bus.red           = rsp.red;
   assign rsp_bus.green         = rsp.green;
   assign rsp_bus.blue          = rsp.blue;
   assign rsp_bus.last_pixel    = rsp.last_pixel;
   assign rsp_bus.line_rejected = rsp.line_rejected;

endmodule

// ----- rtl/glrd_checker.sv -----
`timescale 1ns / 1ps
// port-level checks on the pixel channel, bound to the rasterizer top level
// depends on gouraud_line_dda_rasterizer
module glrd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        pixel_valid,
   input logic [10:0] pixel_x,
   input logic [10:0] pixel_y,
   input logic        last_pixel,
   input logic        line_rejected
);

   a_reject_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && line_rejected |-> last_pixel && !pixel_valid)
      else $error("rejected line beat not marked last or shows a pixel");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && line_rejected |-> pixel_x == 11'd0 && pixel_y == 11'd0)
      else $error("rejected line beat carries a position");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pixel_x) && $stable(pixel_y) &&
                                  $stable(last_pixel) && $stable(line_rejected))
      else $error("stalled result beat changed");

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat right after reset");

endmodule

bind gouraud_line_dda_rasterizer glrd_checker u_glrd_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .pixel_valid   (rsp_bus.pixel_valid),
   .pixel_x       (rsp_bus.pixel_x),
   .pixel_y       (rsp_bus.pixel_y),
   .last_pixel    (rsp_bus.last_pixel),
   .line_rejected (rsp_bus.line_rejected)
);
